// ===== design/best_rational_approximation_assert.svh =====
// ------------------------------------------------------------------------------
// Assertion macros for the best rational approximation block
// Wraps clocked implication checks with a common reset guard and error report.
// ------------------------------------------------------------------------------
`ifndef BEST_RATIONAL_APPROXIMATION_ASSERT_SVH
`define BEST_RATIONAL_APPROXIMATION_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define BRA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("bra check failed");

// next-cycle implication, disabled while reset is low
`define BRA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("bra check failed");

`endif

// ===== design/bra_pkg.sv =====
// ------------------------------------------------------------------------------
// Best rational approximation package
// Shared widths, operation codes and the controller/datapath interface types.
// ------------------------------------------------------------------------------
package bra_pkg;

  // fixed field widths
  localparam int VW   = 32;  // input value
  localparam int KW   = 16;  // denominators
  localparam int ACCW = 64;  // multiply-accumulate register
  localparam int DSW  = 50;  // distance terms |h*2^F - v*k|

  localparam logic [KW-1:0] MAX_DEN_RESET = 16'd1000;

  // register index of max_denominator (paddr bit 2)
  localparam logic REG_MAX_DEN = 1'b0;

  // multiply-accumulate operations
  localparam logic [2:0] MOP_KN  = 3'd0;  // k1*a + k0
  localparam logic [2:0] MOP_HN  = 3'd1;  // h1*a + h0
  localparam logic [2:0] MOP_KS  = 3'd2;  // k1*t + k0
  localparam logic [2:0] MOP_HS  = 3'd3;  // h1*t + h0
  localparam logic [2:0] MOP_VK1 = 3'd4;  // v*k1
  localparam logic [2:0] MOP_VKS = 3'd5;  // v*ks
  localparam logic [2:0] MOP_DSK = 3'd6;  // ds*k1
  localparam logic [2:0] MOP_DCK = 3'd7;  // dc*ks

  // divider operand select
  localparam logic DSEL_EUCLID = 1'b0;
  localparam logic DSEL_SEMI   = 1'b1;

  // result select
  localparam logic [1:0] ESEL_EXACT = 2'd0;
  localparam logic [1:0] ESEL_CONV  = 2'd1;
  localparam logic [1:0] ESEL_SEMI  = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic       load;
    logic       mul_lo;
    logic       mul_hi;
    logic       wb;
    logic       div_start;
    logic       div_take;
    logic       emit;
    logic [2:0] mop;
    logic       dsel;
    logic [1:0] esel;
  } bra_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic kn_over;
    logic r_zero;
    logic take_semi;
    logic div_busy;
    logic out_free;
  } bra_stat_t;

endpackage

// ===== design/bra_div.sv =====
// ------------------------------------------------------------------------------
// Iterative unsigned divider
// Restoring division, one quotient bit per cycle.
// ------------------------------------------------------------------------------
module bra_div #(
  parameter int W = 17
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] dividend_i,
  input  logic [W-1:0] divisor_i,
  output logic         busy_o,
  output logic [W-1:0] quot_o,
  output logic [W-1:0] rem_o
);

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  quo_q, quo_d;
  logic [W-1:0]  rem_q, rem_d;
  logic [W-1:0]  dvs_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic [W:0]    trial;
  logic [W:0]    diff;

  // one restoring step
  always_comb begin
    trial = {rem_q, quo_q[W-1]};
    diff  = trial - {1'b0, dvs_q};
    quo_d = quo_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = CW'(W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = diff[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b1};
      end else begin
        rem_d = trial[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b0};
      end
      cnt_d  = cnt_q - CW'(1);
      busy_d = (cnt_q != CW'(1));
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // operands and partial results
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

// ===== design/bra_datapath.sv =====
// ------------------------------------------------------------------------------
// Best rational approximation datapath
// Euclid remainders, convergent registers, shared multiply-accumulate unit,
// shared divider and the output register.
// ------------------------------------------------------------------------------
module bra_datapath #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bra_pkg::bra_cmd_t cmd_i,
  output bra_pkg::bra_stat_t stat_o,
  input  logic [31:0]       value_i,
  input  logic [15:0]       max_den_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [31:0]       numerator_o,
  output logic [15:0]       denominator_o,
  output logic              exact_o
);

  localparam int QW   = FRAC_BITS + 1;
  localparam int DW   = (QW > 16) ? QW : 16;
  localparam int HW   = 49 - FRAC_BITS;
  localparam int KW   = bra_pkg::KW;
  localparam int ACCW = bra_pkg::ACCW;
  localparam int DSW  = bra_pkg::DSW;

  localparam logic [31:0] FMASK = 32'((64'd1 << FRAC_BITS) - 64'd1);
  localparam logic [QW-1:0] Q1  = QW'(1) << FRAC_BITS;

  function automatic logic [DSW-1:0] absdiff(input logic [DSW-1:0] x,
                                             input logic [DSW-1:0] y);
    absdiff = (x >= y) ? (x - y) : (y - x);
  endfunction

  // item and euclid state
  logic [31:0]     v_q;
  logic [KW-1:0]   md_q;
  logic [QW-1:0]   p_q, q_q, r_q;
  logic [31:0]     a_q;
  logic [KW-1:0]   t_q;
  // convergents and semiconvergent
  logic [HW-1:0]   h1_q, h0_q, hs_q;
  logic [KW-1:0]   k1_q, k0_q, kn_q, ks_q;
  // distances and cross product
  logic [DSW-1:0]  dc_q, ds_q;
  logic [ACCW-1:0] lhs_q;
  logic [ACCW-1:0] acc_q, acc_d;
  // output register
  logic            out_valid_q;
  logic [31:0]     num_q;
  logic [KW-1:0]   den_q;
  logic            exact_q;

  logic [ACCW-1:0] mul_a;
  logic [31:0]     mul_b;
  logic [ACCW-1:0] mul_c;
  logic [31:0]     mul_half;
  logic [63:0]     prod;
  logic [DW-1:0]   div_n, div_d, div_quot, div_rem;
  logic            div_busy;
  logic [DSW-1:0]  h1_sh, hs_sh;
  logic [HW-1:0]   e_h;
  logic [KW-1:0]   e_k;
  logic            e_ex;
  logic            e_sat;
  logic            out_free;

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    mul_c = '0;
    case (cmd_i.mop)
      bra_pkg::MOP_KN: begin
        mul_a = ACCW'(a_q);
        mul_b = 32'(k1_q);
        mul_c = ACCW'(k0_q);
      end
      bra_pkg::MOP_HN: begin
        mul_a = ACCW'(h1_q);
        mul_b = a_q;
        mul_c = ACCW'(h0_q);
      end
      bra_pkg::MOP_KS: begin
        mul_a = ACCW'(t_q);
        mul_b = 32'(k1_q);
        mul_c = ACCW'(k0_q);
      end
      bra_pkg::MOP_HS: begin
        mul_a = ACCW'(h1_q);
        mul_b = 32'(t_q);
        mul_c = ACCW'(h0_q);
      end
      bra_pkg::MOP_VK1: begin
        mul_a = ACCW'(v_q);
        mul_b = 32'(k1_q);
      end
      bra_pkg::MOP_VKS: begin
        mul_a = ACCW'(v_q);
        mul_b = 32'(ks_q);
      end
      bra_pkg::MOP_DSK: begin
        mul_a = ACCW'(ds_q);
        mul_b = 32'(k1_q);
      end
      bra_pkg::MOP_DCK: begin
        mul_a = ACCW'(dc_q);
        mul_b = 32'(ks_q);
      end
      default: ;
    endcase
  end

  // 32x32 multiplier, low half then high half of operand a
  assign mul_half = cmd_i.mul_hi ? mul_a[63:32] : mul_a[31:0];
  assign prod     = mul_half * mul_b;

  always_comb begin
    acc_d = acc_q;
    if (cmd_i.mul_lo) begin
      acc_d = prod + mul_c;
    end else if (cmd_i.mul_hi) begin
      acc_d = acc_q + {prod[31:0], 32'b0};
    end
  end

  // divider operands
  assign div_n = (cmd_i.dsel == bra_pkg::DSEL_SEMI) ? DW'(md_q - k0_q) : DW'(p_q);
  assign div_d = (cmd_i.dsel == bra_pkg::DSEL_SEMI) ? DW'(k1_q) : DW'(q_q);

  bra_div #(
    .W (DW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_n),
    .divisor_i  (div_d),
    .busy_o     (div_busy),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // numerators scaled to the fixed-point grid
  assign h1_sh = DSW'(h1_q) << FRAC_BITS;
  assign hs_sh = DSW'(hs_q) << FRAC_BITS;

  // result select and saturation
  always_comb begin
    case (cmd_i.esel)
      bra_pkg::ESEL_EXACT: begin
        e_h  = h1_q;
        e_k  = k1_q;
        e_ex = 1'b1;
      end
      bra_pkg::ESEL_SEMI: begin
        e_h  = hs_q;
        e_k  = ks_q;
        e_ex = (ds_q == '0);
      end
      default: begin
        e_h  = h1_q;
        e_k  = k1_q;
        e_ex = (dc_q == '0);
      end
    endcase
    e_sat = (64'(e_h) > 64'h0000_0000_FFFF_FFFF);
  end

  assign out_free = !out_valid_q || out_ready_i;

  // working registers
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (cmd_i.load) begin
      v_q  <= value_i;
      md_q <= (max_den_i == '0) ? KW'(1) : max_den_i;
      a_q  <= value_i >> FRAC_BITS;
      r_q  <= QW'(value_i & FMASK);
      q_q  <= Q1;
      h1_q <= HW'(1);
      h0_q <= '0;
      k1_q <= '0;
      k0_q <= KW'(1);
    end
    if (cmd_i.div_take) begin
      if (cmd_i.dsel == bra_pkg::DSEL_SEMI) begin
        t_q <= div_quot[KW-1:0];
      end else begin
        a_q <= 32'(div_quot);
        r_q <= div_rem[QW-1:0];
      end
    end
    if (cmd_i.wb) begin
      case (cmd_i.mop)
        bra_pkg::MOP_KN:  kn_q <= acc_q[KW-1:0];
        bra_pkg::MOP_HN: begin
          h0_q <= h1_q;
          h1_q <= acc_q[HW-1:0];
          k0_q <= k1_q;
          k1_q <= kn_q;
          p_q  <= q_q;
          q_q  <= r_q;
        end
        bra_pkg::MOP_KS:  ks_q  <= acc_q[KW-1:0];
        bra_pkg::MOP_HS:  hs_q  <= acc_q[HW-1:0];
        bra_pkg::MOP_VK1: dc_q  <= absdiff(h1_sh, acc_q[DSW-1:0]);
        bra_pkg::MOP_VKS: ds_q  <= absdiff(hs_sh, acc_q[DSW-1:0]);
        bra_pkg::MOP_DSK: lhs_q <= acc_q;
        default: ;
      endcase
    end
    if (cmd_i.emit) begin
      num_q   <= e_sat ? 32'hFFFF_FFFF : 32'(e_h);
      den_q   <= e_k;
      exact_q <= e_ex && !e_sat;
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // status back to the controller
  assign stat_o.kn_over   = (acc_q > ACCW'(md_q));
  assign stat_o.r_zero    = (r_q == '0);
  assign stat_o.take_semi = (lhs_q < acc_q);
  assign stat_o.div_busy  = div_busy;
  assign stat_o.out_free  = out_free;

  assign out_valid_o   = out_valid_q;
  assign numerator_o   = num_q;
  assign denominator_o = den_q;
  assign exact_o       = exact_q;

endmodule

// ===== design/bra_ctrl.sv =====
// ------------------------------------------------------------------------------
// Best rational approximation controller
// Sequences load, euclid steps, the semiconvergent comparison and the result.
// ------------------------------------------------------------------------------
module bra_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  bra_pkg::bra_stat_t stat_i,
  output bra_pkg::bra_cmd_t  cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MLO    = 3'd1;
  localparam logic [2:0] S_MHI    = 3'd2;
  localparam logic [2:0] S_WB     = 3'd3;
  localparam logic [2:0] S_DSTART = 3'd4;
  localparam logic [2:0] S_DWAIT  = 3'd5;
  localparam logic [2:0] S_EMIT   = 3'd6;

  logic [2:0] state_q, state_d;
  logic [2:0] mop_q, mop_d;
  logic       dsel_q, dsel_d;
  logic [1:0] esel_q, esel_d;

  // next state and commands
  always_comb begin
    state_d = state_q;
    mop_d   = mop_q;
    dsel_d  = dsel_q;
    esel_d  = esel_q;
    cmd_o           = '0;
    cmd_o.mop       = mop_q;
    cmd_o.dsel      = dsel_q;
    cmd_o.esel      = esel_q;
    in_ready_o      = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          mop_d      = bra_pkg::MOP_KN;
          state_d    = S_MLO;
        end
      end
      S_MLO: begin
        cmd_o.mul_lo = 1'b1;
        state_d      = S_MHI;
      end
      S_MHI: begin
        cmd_o.mul_hi = 1'b1;
        state_d      = S_WB;
      end
      S_WB: begin
        cmd_o.wb = 1'b1;
        state_d  = S_MLO;
        case (mop_q)
          bra_pkg::MOP_KN: begin
            // bound exceeded: go for the semiconvergent
            if (stat_i.kn_over) begin
              dsel_d  = bra_pkg::DSEL_SEMI;
              state_d = S_DSTART;
            end else begin
              mop_d = bra_pkg::MOP_HN;
            end
          end
          bra_pkg::MOP_HN: begin
            // zero remainder ends an exact expansion
            if (stat_i.r_zero) begin
              esel_d  = bra_pkg::ESEL_EXACT;
              state_d = S_EMIT;
            end else begin
              dsel_d  = bra_pkg::DSEL_EUCLID;
              state_d = S_DSTART;
            end
          end
          bra_pkg::MOP_KS:  mop_d = bra_pkg::MOP_HS;
          bra_pkg::MOP_HS:  mop_d = bra_pkg::MOP_VK1;
          bra_pkg::MOP_VK1: mop_d = bra_pkg::MOP_VKS;
          bra_pkg::MOP_VKS: mop_d = bra_pkg::MOP_DSK;
          bra_pkg::MOP_DSK: mop_d = bra_pkg::MOP_DCK;
          default: begin
            // tie keeps the convergent
            esel_d  = stat_i.take_semi ? bra_pkg::ESEL_SEMI : bra_pkg::ESEL_CONV;
            state_d = S_EMIT;
          end
        endcase
      end
      S_DSTART: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DWAIT;
      end
      S_DWAIT: begin
        if (!stat_i.div_busy) begin
          cmd_o.div_take = 1'b1;
          mop_d   = (dsel_q == bra_pkg::DSEL_SEMI) ? bra_pkg::MOP_KS : bra_pkg::MOP_KN;
          state_d = S_MLO;
        end
      end
      S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mop_q   <= bra_pkg::MOP_KN;
      dsel_q  <= bra_pkg::DSEL_EUCLID;
      esel_q  <= bra_pkg::ESEL_EXACT;
    end else begin
      state_q <= state_d;
      mop_q   <= mop_d;
      dsel_q  <= dsel_d;
      esel_q  <= esel_d;
    end
  end

endmodule

// ===== design/best_rational_approximation.sv =====
// ------------------------------------------------------------------------------
// Best rational approximation of an unsigned Q16.16 value
// Input item: value. Result item: numerator/denominator nearest to value with
// denominator no larger than max_denominator, plus an exact flag in m_tuser.
// Usage: write max_denominator at byte address 0 over the APB port while idle
// (0 acts as 1, reset value 1000). Send one value per item on s_*; exactly one
// result comes out on m_* for each. One item is in work at a time: s_tready is
// high only while the block waits for an item.
// The first continued-fraction term needs no division; each further term uses
// the restoring divider, DW = max(FRAC_BITS+1, 16) bits wide, that does one
// quotient bit per cycle. When the bound stops the expansion, the semiconvergent
// compare follows, then the result is written. At most 24 terms are taken,
// since denominators grow at least like Fibonacci numbers.
// The result waits in an output register; a stall on m_tready holds it and
// lets the next item be accepted and worked on, only its final write waits.
// Reset clears the controller, divider and output valid; no clearing pass.
// ------------------------------------------------------------------------------
module best_rational_approximation #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input item stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value
  // result item stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [31:0] numerator, [47:32] denominator
  output logic        m_tuser,   // [0] exact
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0]        max_den_q;
  logic               cfg_wr;
  bra_pkg::bra_cmd_t  cmd;
  bra_pkg::bra_stat_t stat;
  logic [31:0]        numerator;
  logic [15:0]        denominator;

  // configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == bra_pkg::REG_MAX_DEN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_den_q <= bra_pkg::MAX_DEN_RESET;
    end else if (cfg_wr) begin
      max_den_q <= pwdata[15:0];
    end
  end

  assign prdata = (paddr[2] == bra_pkg::REG_MAX_DEN) ? {16'b0, max_den_q} : '0;

  bra_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_tvalid),
    .in_ready_o (s_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  bra_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .value_i       (s_tdata),
    .max_den_i     (max_den_q),
    .out_ready_i   (m_tready),
    .out_valid_o   (m_tvalid),
    .numerator_o   (numerator),
    .denominator_o (denominator),
    .exact_o       (m_tuser)
  );

  assign m_tdata = {denominator, numerator};

endmodule

// ===== design/bra_checker.sv =====
// ------------------------------------------------------------------------------
// Best rational approximation port checker
// Watches the top-level ports for handshake and result sanity.
// ------------------------------------------------------------------------------
`include "best_rational_approximation_assert.svh"

module bra_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [31:0] s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata,
  input logic        m_tuser
);

  logic unused_ok;
  assign unused_ok = ^{s_tdata, m_tuser};

  // a stalled result stays offered and unchanged
  `BRA_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_tvalid && !m_tready, m_tvalid)
  `BRA_ASSERT_NXT(a_out_stable, clk_i, rst_ni, m_tvalid && !m_tready, $stable(m_tdata))

  // denominators are never zero
  `BRA_ASSERT_IMP(a_den_nonzero, clk_i, rst_ni, m_tvalid, m_tdata[47:32] != 16'd0)

  // one item at a time: an accepted item keeps the input closed next cycle
  `BRA_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, s_tvalid && s_tready, !s_tready)

endmodule

bind best_rational_approximation bra_checker u_bra_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// ===== tb/best_rational_approximation_tb.sv =====
// ------------------------------------------------------------------------------
// Best rational approximation testbench
// Streams Q16.16 values into the block under several max_denominator settings
// and checks every result item against a continued-fraction predictor run on
// the same value and bound. Both stream sides idle at random; the receiver
// also holds off for long stretches so the block stalls its input.
// ------------------------------------------------------------------------------
module best_rational_approximation_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC_BITS = 16;

  typedef struct packed {
    logic [31:0] num;
    logic [15:0] den;
    logic        exact;
  } frac_t;

  logic        clk_i    = 1'b0;
  logic        rst_ni   = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic        m_tuser;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [2:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;

  // testbench copy of the register
  logic [15:0] max_den = bra_pkg::MAX_DEN_RESET;

  logic [31:0] value_q[$];
  frac_t       expected_fracs[$];
  int          n_accepted  = 0;
  int          n_errors    = 0;
  int          send_gap    = 0;
  int          recv_gap    = 0;
  bit          calm        = 1'b0;
  logic        rx_hold     = 1'b0;

  best_rational_approximation #(.FRAC_BITS(FRAC_BITS)) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #1 clk_i = ~clk_i;

  // numerator saturates at 32 bits and then is never exact
  function automatic frac_t make_frac(input logic [63:0] h, input logic [63:0] k,
                                      input bit ex);
    frac_t f;
    bit    sat;
    sat     = h > 64'hFFFF_FFFF;
    f.num   = sat ? 32'hFFFF_FFFF : h[31:0];
    f.den   = k[15:0];
    f.exact = ex && !sat;
    return f;
  endfunction

  // |h*2^F - v*k|
  function automatic logic [63:0] gap_num(input logic [63:0] h, input logic [63:0] k,
                                          input logic [63:0] v, input logic [63:0] q);
    logic [63:0] a;
    logic [63:0] b;
    a = h * q;
    b = v * k;
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  // nearest fraction with denominator within the bound
  function automatic frac_t best_fraction(input logic [31:0] v, input logic [15:0] bound);
    logic [63:0] one_q, md, p, q, a, r, h1, h0, k1, k0, hn, kn;
    logic [63:0] t, hs, ks, dc, ds;
    bit          stop;
    bit          hit;
    int          n;
    one_q = 64'd1 << FRAC_BITS;
    md    = (bound == 16'd0) ? 64'd1 : {48'd0, bound};
    p     = {32'd0, v};
    q     = one_q;
    h1 = 64'd1; h0 = 64'd0; k1 = 64'd0; k0 = 64'd1;
    stop = 1'b0; hit = 1'b0; n = 0;
    // expand until the bound stops it or the expansion ends exactly
    while (!stop && n < 128) begin
      a = p / q;
      r = p - a * q;
      if (k1 * a + k0 > md) begin
        stop = 1'b1;
      end else begin
        hn = h1 * a + h0;
        kn = k1 * a + k0;
        h0 = h1; h1 = hn;
        k0 = k1; k1 = kn;
        if (r == 64'd0) begin
          hit  = 1'b1;
          stop = 1'b1;
        end else begin
          p = q;
          q = r;
        end
      end
      n++;
    end
    if (hit) return make_frac(h1, k1, 1'b1);
    // convergent against bounded semiconvergent, tie keeps the convergent
    t  = (md - k0) / k1;
    hs = h1 * t + h0;
    ks = k1 * t + k0;
    dc = gap_num(h1, k1, {32'd0, v}, one_q);
    ds = gap_num(hs, ks, {32'd0, v}, one_q);
    if (ds * k1 < dc * ks) return make_frac(hs, ks, ds == 64'd0);
    return make_frac(h1, k1, dc == 64'd0);
  endfunction

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [31:0] gen_value();
    logic [63:0] n;
    logic [63:0] d;
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 32'h000F_FFFF);
      2: begin
        // near a fraction with a small denominator
        n = $urandom_range(1, 2000);
        d = $urandom_range(1, 300);
        return 32'((n << FRAC_BITS) / d);
      end
      3: return $urandom() & 32'hFFFF_F000;
      4: return (32'd1 << $urandom_range(0, 31)) | (32'd1 << $urandom_range(0, 31));
      default: return 32'hFFFF_FFFF - $urandom_range(0, 1000);
    endcase
  endfunction

  task automatic note_error(input string msg);
    n_errors++;
    if (n_errors <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  // input side: offer queued items, predict each accepted one
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_fracs.push_back(best_fraction(s_tdata, max_den));
        n_accepted++;
      end
      if (!s_tvalid || s_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_tvalid <= 1'b0;
        end else if (value_q.size() > 0) begin
          s_tdata  <= value_q.pop_front();
          s_tvalid <= 1'b1;
          send_gap = pick_gap();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // output side: random ready, compare against the oldest expectation
  always @(posedge clk_i) begin
    frac_t want;
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_fracs.size() == 0) begin
          note_error($sformatf("unexpected result %0d/%0d", m_tdata[31:0], m_tdata[47:32]));
        end else begin
          want = expected_fracs.pop_front();
          if (m_tdata[31:0] !== want.num)
            note_error($sformatf("numerator exp %0d got %0d", want.num, m_tdata[31:0]));
          if (m_tdata[47:32] !== want.den)
            note_error($sformatf("denominator exp %0d got %0d", want.den, m_tdata[47:32]));
          if (m_tuser !== want.exact)
            note_error($sformatf("exact exp %0b got %0b", want.exact, m_tuser));
        end
      end
      if (rx_hold) begin
        m_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0) recv_gap = pick_gap();
      end
    end
  end

  // long receiver hold-offs while the sender keeps offering
  initial begin
    wait (n_accepted >= 60);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (3000) @(posedge clk_i);
    rx_hold <= 1'b0;
    wait (n_accepted >= 280);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (1500) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  task automatic write_max_den(input logic [31:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {bra_pkg::REG_MAX_DEN, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    max_den = data[15:0];
  endtask

  // sender pause until every result is back
  task automatic drain();
    while (value_q.size() != 0 || s_tvalid || expected_fracs.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic send_extremes();
    value_q.push_back(32'h0000_0000);
    value_q.push_back(32'hFFFF_FFFF);
    value_q.push_back(32'h0000_0001);
    value_q.push_back(32'h0001_0000);
    value_q.push_back(32'hFFFF_0000);
  endtask

  // stimulus
  initial begin
    logic [15:0] bound;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset bound, extremes and well-known constants
    send_extremes();
    value_q.push_back(32'h0003_243F);  // pi
    value_q.push_back(32'h0002_B7E1);  // e
    value_q.push_back(32'h0001_9E37);  // golden ratio
    value_q.push_back(32'h0000_8000);
    drain();

    // widest bound
    write_max_den(32'hA5A5_FFFF);
    send_extremes();
    value_q.push_back(32'h5555_5555);
    value_q.push_back(32'h0001_6A0A);  // sqrt 2
    drain();

    // zero bound acts as one
    write_max_den(32'h0000_0000);
    value_q.push_back(32'h0000_7FFF);
    value_q.push_back(32'h0000_8000);
    value_q.push_back(32'h8000_C000);
    drain();

    // bound of one
    write_max_den(32'h5A5A_0001);
    value_q.push_back(32'h0000_8001);
    value_q.push_back(32'h0000_FFFF);
    value_q.push_back(32'h0002_4000);
    drain();

    // random phases
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: bound = 16'd65535;
        1: bound = 16'd1;
        2: bound = 16'd0;
        3: bound = 16'd2;
        4: bound = bra_pkg::MAX_DEN_RESET;
        5: bound = 16'd65534;
        default: bound = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(3, 200))
                                                     : 16'($urandom_range(1, 65535));
      endcase
      write_max_den({16'($urandom()), bound});
      calm = (ph % 4 == 3);
      for (int i = 0; i < 56; i++) value_q.push_back(gen_value());
      drain();
    end
    calm = 1'b0;

    repeat (50) @(posedge clk_i);
    if (expected_fracs.size() != 0) note_error("results missing at end of run");
    if (n_errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // timeout
  initial begin
    #6ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
